### design/sclw_pkg.sv
// Shared types and constants for the display RAM write-window command decoder.
// Used by sclw_front, sclw_act_queue, sclw_back and the top level; no dependencies.
package sclw_pkg;

  // Display geometry
  localparam int ROWS    = 320;
  localparam int COLS    = 240;
  localparam int COL_W   = 8;
  localparam int ROW_W   = 9;
  localparam int ADDR_W  = 17;
  localparam int PIX_CNT = ROWS * COLS;

  // Reciprocal constants for reducing a 16-bit word modulo COLS or ROWS
  localparam int COL_SH  = 16 + $clog2(COLS);
  localparam int ROW_SH  = 16 + $clog2(ROWS);
  localparam int COL_MUL = ((1 << COL_SH) + COLS - 1) / COLS;
  localparam int ROW_MUL = ((1 << ROW_SH) + ROWS - 1) / ROWS;
  localparam int MUL_W   = 17;

  // Action queue depth
  localparam int AQ_DEPTH = 4;
  localparam int AQ_AW    = $clog2(AQ_DEPTH);

  // Command words
  localparam logic [15:0] CMD_NOP       = 16'h0000;
  localparam logic [15:0] CMD_WAKE      = 16'h0011;
  localparam logic [15:0] CMD_DISP_ON   = 16'h0029;
  localparam logic [15:0] CMD_COL_WIN   = 16'h002A;
  localparam logic [15:0] CMD_ROW_WIN   = 16'h002B;
  localparam logic [15:0] CMD_MEM_WRITE = 16'h002C;
  localparam logic [15:0] CMD_ADDR_MODE = 16'h0036;
  localparam logic [15:0] CMD_PIX_FMT   = 16'h003A;

  // Pixel format code for 16 bits per pixel
  localparam logic [2:0] PIXFMT_16BPP = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_UNKNOWN    = 2'd1;
  localparam logic [1:0] ST_BAD_PIXFMT = 2'd2;

  // Input opcodes
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_DC_LINE = 1'b1;

  // Work handed from the decoder to the executor
  typedef enum logic [2:0] {
    ACT_REPORT,
    ACT_COL_WIN,
    ACT_ROW_WIN,
    ACT_HOME,
    ACT_PIXEL
  } act_e;

  typedef struct packed {
    act_e        act;
    logic [1:0]  status;
    logic [15:0] word0;
    logic [15:0] word1;
  } act_t;

  typedef struct packed {
    logic       op;
    logic       dc_level;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic              pixel_write;
    logic [ADDR_W-1:0] pixel_address;
    logic [15:0]       pixel_value;
    logic [1:0]        status;
  } res_t;

endpackage

### design/spi_lcd_command_window_writer.sv
// Top level of the display RAM write-window command decoder.
// Depends on sclw_pkg, sclw_front, sclw_act_queue and sclw_back.
//
// Takes one request per clock (serial byte or command/data line change) and
// gives exactly one result per request, in order: a pixel write inside the
// current column/row window, a status code, or an all-zero result. Both sides
// are queues: push while full is low, pop while empty is low. On its way to
// the result ports a request is first written by the decoder as an action
// into a four-entry action queue, then loaded into the reciprocal multiply
// stage that reduces window bounds, and then the window/cursor update and
// the pixel address are written into a two-entry result queue. Sustained
// rate is one request per clock as long as results are popped.
module spi_lcd_command_window_writer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  sclw_pkg::in_t   in_item_i,
  output logic            empty,
  input  logic            pop,
  output sclw_pkg::res_t  res_o
);

  logic           acc;
  logic           aq_valid;
  logic           aq_pop;
  sclw_pkg::act_t act_in;
  sclw_pkg::act_t act_out;

  assign acc = push && !full;

  // Decoder
  sclw_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .in_i   (in_item_i),
    .act_o  (act_in)
  );

  // Decoupling queue
  sclw_act_queue u_act_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (acc),
    .wdata_i (act_in),
    .full_o  (full),
    .pop_i   (aq_pop),
    .valid_o (aq_valid),
    .rdata_o (act_out)
  );

  // Executor
  sclw_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .aq_valid_i (aq_valid),
    .aq_data_i  (act_out),
    .aq_pop_o   (aq_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .res_o      (res_o)
  );

endmodule

### design/sclw_front.sv
// Front end: pairs bytes into words, tracks the command and parameters,
// and turns every request into one action. Depends on sclw_pkg.
module sclw_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            acc_i,
  input  sclw_pkg::in_t   in_i,
  output sclw_pkg::act_t  act_o
);

  logic        data_mode_q, data_mode_d;
  logic        second_q, second_d;
  logic [15:0] cmd_q, cmd_d;
  logic [1:0]  pc_q, pc_d;
  logic [15:0] pw_q [2];
  logic [15:0] pw_d [2];
  logic        idx;

  assign idx = pc_q[0];

  // Word assembly and command dispatch
  always_comb begin
    data_mode_d = data_mode_q;
    second_d    = second_q;
    cmd_d       = cmd_q;
    pc_d        = pc_q;
    pw_d[0]     = pw_q[0];
    pw_d[1]     = pw_q[1];
    act_o       = '{act: sclw_pkg::ACT_REPORT, status: sclw_pkg::ST_OK,
                    word0: 16'h0000, word1: 16'h0000};
    if (acc_i) begin
      if (in_i.op == sclw_pkg::OP_DC_LINE) begin
        data_mode_d = in_i.dc_level;
        second_d    = 1'b0;
      end else begin
        if (!data_mode_q) begin
          // command words: low byte first
          if (second_q) begin
            cmd_d = cmd_q | {in_i.data_byte, 8'h00};
          end else begin
            cmd_d = {8'h00, in_i.data_byte};
          end
          pc_d = 2'd0;
        end else begin
          // parameter words: high byte first
          if (second_q) begin
            pw_d[idx] = pw_q[idx] | {8'h00, in_i.data_byte};
            pc_d      = pc_q + 2'd1;
          end else begin
            pw_d[idx] = {in_i.data_byte, 8'h00};
          end
        end
        second_d = !second_q;

        // word complete: decide what the back end does
        if (second_q) begin
          case (cmd_d)
            sclw_pkg::CMD_NOP, sclw_pkg::CMD_WAKE, sclw_pkg::CMD_DISP_ON: begin
              pc_d = 2'd0;
            end
            sclw_pkg::CMD_COL_WIN: begin
              if (pc_d >= 2'd2) begin
                act_o.act   = sclw_pkg::ACT_COL_WIN;
                act_o.word0 = pw_d[0];
                act_o.word1 = pw_d[1];
                pc_d        = 2'd0;
              end
            end
            sclw_pkg::CMD_ROW_WIN: begin
              if (pc_d >= 2'd2) begin
                act_o.act   = sclw_pkg::ACT_ROW_WIN;
                act_o.word0 = pw_d[0];
                act_o.word1 = pw_d[1];
                pc_d        = 2'd0;
              end
            end
            sclw_pkg::CMD_ADDR_MODE: begin
              if (pc_d >= 2'd1) begin
                pc_d = 2'd0;
              end
            end
            sclw_pkg::CMD_PIX_FMT: begin
              if (pc_d >= 2'd1) begin
                if (pw_d[0][10:8] != sclw_pkg::PIXFMT_16BPP) begin
                  act_o.status = sclw_pkg::ST_BAD_PIXFMT;
                end
                pc_d = 2'd0;
              end
            end
            sclw_pkg::CMD_MEM_WRITE: begin
              if (pc_d == 2'd0) begin
                act_o.act = sclw_pkg::ACT_HOME;
              end else begin
                act_o.act   = sclw_pkg::ACT_PIXEL;
                act_o.word0 = pw_d[0];
                pc_d        = 2'd0;
              end
            end
            default: begin
              act_o.status = sclw_pkg::ST_UNKNOWN;
              pc_d         = 2'd0;
            end
          endcase
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_mode_q <= 1'b0;
      second_q    <= 1'b0;
      cmd_q       <= sclw_pkg::CMD_NOP;
      pc_q        <= 2'd0;
      pw_q[0]     <= 16'h0000;
      pw_q[1]     <= 16'h0000;
    end else begin
      data_mode_q <= data_mode_d;
      second_q    <= second_d;
      cmd_q       <= cmd_d;
      pc_q        <= pc_d;
      pw_q[0]     <= pw_d[0];
      pw_q[1]     <= pw_d[1];
    end
  end

endmodule

### design/sclw_act_queue.sv
// Short queue of actions between the decoder and the executor.
// Depends on sclw_pkg.
module sclw_act_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sclw_pkg::act_t  wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output sclw_pkg::act_t  rdata_o
);

  sclw_pkg::act_t             mem_q [sclw_pkg::AQ_DEPTH];
  logic [sclw_pkg::AQ_AW-1:0] wp_q, rp_q;
  logic [sclw_pkg::AQ_AW:0]   cnt_q, cnt_d;
  logic                       wr, rd;

  assign full_o  = (cnt_q == (sclw_pkg::AQ_AW + 1)'(sclw_pkg::AQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rp_q];
  assign wr      = push_i && !full_o;
  assign rd      = pop_i && valid_o;

  // Occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (wr && !rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd && !wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr) begin
        wp_q <= wp_q + 1'b1;
      end
      if (rd) begin
        rp_q <= rp_q + 1'b1;
      end
    end
  end

  // Entries
  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= sclw_pkg::AQ_DEPTH)
    else $error("action queue overfilled");
`endif

endmodule

### design/sclw_back.sv
// Back end: reduces window bounds modulo the display size, keeps the window
// and cursor, forms the result and buffers it. Depends on sclw_pkg.
module sclw_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            aq_valid_i,
  input  sclw_pkg::act_t  aq_data_i,
  output logic            aq_pop_o,
  input  logic            pop_i,
  output logic            empty_o,
  output sclw_pkg::res_t  res_o
);

  // Reduce x modulo ROWS or COLS given a quotient estimate
  function automatic logic [15:0] mod_fix(logic [15:0] x, logic [15:0] q, logic is_row);
    logic [25:0] qd;
    logic [25:0] dv;
    logic [25:0] t;
    qd = is_row ? 26'(q) * 26'(sclw_pkg::ROWS) : 26'(q) * 26'(sclw_pkg::COLS);
    dv = is_row ? 26'(sclw_pkg::ROWS) : 26'(sclw_pkg::COLS);
    t  = 26'(x) - qd;
    if (t >= dv) begin
      t = t - dv;
    end
    return t[15:0];
  endfunction

  // Stage 1: quotient estimates
  logic                          is_row_s0;
  logic [sclw_pkg::MUL_W-1:0]    mul_s0;
  logic [32:0]                   prod0_s0, prod1_s0;
  logic [15:0]                   q0_s0, q1_s0;
  sclw_pkg::act_t                s1_q;
  logic [15:0]                   s1_q0_q, s1_q1_q;
  logic                          s1_valid_q;
  logic                          s1_load, s2_fire;

  // Stage 2: window and cursor state
  logic [sclw_pkg::COL_W-1:0]    col_cur_q, col_cur_d, col_first_q, col_first_d;
  logic [sclw_pkg::COL_W-1:0]    col_last_q, col_last_d;
  logic [sclw_pkg::ROW_W-1:0]    row_cur_q, row_cur_d, row_first_q, row_first_d;
  logic [sclw_pkg::ROW_W-1:0]    row_last_q, row_last_d;
  logic                          is_row_s1;
  logic [15:0]                   r0_s1, r1_s1;
  logic [sclw_pkg::COL_W:0]      c_next;
  logic [sclw_pkg::ROW_W:0]      r_next;
  sclw_pkg::res_t                res_d;

  // Result queue
  sclw_pkg::res_t                rq_mem_q [2];
  logic                          rq_wp_q, rq_rp_q;
  logic [1:0]                    rq_cnt_q;
  logic                          rq_full, rq_rd;

  assign rq_full  = (rq_cnt_q == 2'd2);
  assign empty_o  = (rq_cnt_q == 2'd0);
  assign rq_rd    = pop_i && !empty_o;
  assign res_o    = rq_mem_q[rq_rp_q];

  assign s2_fire  = s1_valid_q && !rq_full;
  assign s1_load  = aq_valid_i && (!s1_valid_q || s2_fire);
  assign aq_pop_o = s1_load;

  // Reciprocal multiply for both window bounds
  assign is_row_s0 = (aq_data_i.act == sclw_pkg::ACT_ROW_WIN);
  assign mul_s0    = is_row_s0 ? sclw_pkg::MUL_W'(sclw_pkg::ROW_MUL)
                               : sclw_pkg::MUL_W'(sclw_pkg::COL_MUL);
  assign prod0_s0  = 33'(aq_data_i.word0) * 33'(mul_s0);
  assign prod1_s0  = 33'(aq_data_i.word1) * 33'(mul_s0);
  assign q0_s0     = is_row_s0 ? 16'(prod0_s0 >> sclw_pkg::ROW_SH)
                               : 16'(prod0_s0 >> sclw_pkg::COL_SH);
  assign q1_s0     = is_row_s0 ? 16'(prod1_s0 >> sclw_pkg::ROW_SH)
                               : 16'(prod1_s0 >> sclw_pkg::COL_SH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= 1'b1;
    end else if (s2_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_q    <= aq_data_i;
      s1_q0_q <= q0_s0;
      s1_q1_q <= q1_s0;
    end
  end

  // Remainders for the window bounds
  assign is_row_s1 = (s1_q.act == sclw_pkg::ACT_ROW_WIN);
  assign r0_s1     = mod_fix(s1_q.word0, s1_q0_q, is_row_s1);
  assign r1_s1     = mod_fix(s1_q.word1, s1_q1_q, is_row_s1);

  // Cursor step: column first, then row, wrapping to the window start
  always_comb begin
    c_next = {1'b0, col_cur_q} + 1'b1;
    r_next = {1'b0, row_cur_q};
    if (c_next > {1'b0, col_last_q}) begin
      r_next = {1'b0, row_cur_q} + 1'b1;
      c_next = {1'b0, col_first_q};
    end
    if (r_next > {1'b0, row_last_q}) begin
      r_next = {1'b0, row_first_q};
    end
  end

  // Action execution and result formation
  always_comb begin
    col_cur_d   = col_cur_q;
    col_first_d = col_first_q;
    col_last_d  = col_last_q;
    row_cur_d   = row_cur_q;
    row_first_d = row_first_q;
    row_last_d  = row_last_q;
    res_d       = '0;
    if (s2_fire) begin
      case (s1_q.act)
        sclw_pkg::ACT_REPORT: begin
          res_d.status = s1_q.status;
        end
        sclw_pkg::ACT_COL_WIN: begin
          col_first_d = sclw_pkg::COL_W'(r0_s1);
          col_cur_d   = sclw_pkg::COL_W'(r0_s1);
          col_last_d  = sclw_pkg::COL_W'(r1_s1);
        end
        sclw_pkg::ACT_ROW_WIN: begin
          row_first_d = sclw_pkg::ROW_W'(r0_s1);
          row_cur_d   = sclw_pkg::ROW_W'(r0_s1);
          row_last_d  = sclw_pkg::ROW_W'(r1_s1);
        end
        sclw_pkg::ACT_HOME: begin
          col_cur_d = col_first_q;
          row_cur_d = row_first_q;
        end
        sclw_pkg::ACT_PIXEL: begin
          res_d.pixel_write   = 1'b1;
          res_d.pixel_address = sclw_pkg::ADDR_W'(col_cur_q)
                              + sclw_pkg::ADDR_W'(row_cur_q)
                              * sclw_pkg::ADDR_W'(sclw_pkg::COLS);
          res_d.pixel_value   = s1_q.word0;
          col_cur_d           = c_next[sclw_pkg::COL_W-1:0];
          row_cur_d           = r_next[sclw_pkg::ROW_W-1:0];
        end
        default: begin
          res_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cur_q   <= '0;
      col_first_q <= '0;
      col_last_q  <= sclw_pkg::COL_W'(sclw_pkg::COLS - 1);
      row_cur_q   <= '0;
      row_first_q <= '0;
      row_last_q  <= sclw_pkg::ROW_W'(sclw_pkg::ROWS - 1);
    end else begin
      col_cur_q   <= col_cur_d;
      col_first_q <= col_first_d;
      col_last_q  <= col_last_d;
      row_cur_q   <= row_cur_d;
      row_first_q <= row_first_d;
      row_last_q  <= row_last_d;
    end
  end

  // Result queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wp_q  <= 1'b0;
      rq_rp_q  <= 1'b0;
      rq_cnt_q <= 2'd0;
    end else begin
      if (s2_fire) begin
        rq_wp_q <= !rq_wp_q;
      end
      if (rq_rd) begin
        rq_rp_q <= !rq_rp_q;
      end
      if (s2_fire && !rq_rd) begin
        rq_cnt_q <= rq_cnt_q + 2'd1;
      end else if (rq_rd && !s2_fire) begin
        rq_cnt_q <= rq_cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      rq_mem_q[rq_wp_q] <= res_d;
    end
  end

`ifndef SYNTHESIS
  a_row_in_display: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(row_cur_q) < sclw_pkg::ROWS)
    else $error("row cursor left the display");

  a_col_in_display: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_cur_q) < sclw_pkg::COLS)
    else $error("column cursor left the display");

  a_pixel_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_fire && s1_q.act == sclw_pkg::ACT_PIXEL) |->
      32'(res_d.pixel_address) < sclw_pkg::PIX_CNT)
    else $error("pixel address beyond frame memory");
`endif

endmodule
